[hw/rtl/frmr_pkg.sv]
// Shared types, codes and constants of the flow rule match and rewrite block.
`default_nettype none

package frmr_pkg;

    // Table depth default
    localparam int DEFAULT_NUM_RULES = 16;

    // Port counters start here after reset
    localparam logic [15:0] PORT_CNT_START = 16'd1024;

    // Request codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Per-field rewrite modes; the fourth code behaves as copy
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_AUTO  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_ALT   = 2'd3;

    // Field part of word_select
    localparam logic [1:0] FLD_SRC_IP   = 2'd0;
    localparam logic [1:0] FLD_SRC_PORT = 2'd1;
    localparam logic [1:0] FLD_DST_IP   = 2'd2;
    localparam logic [1:0] FLD_DST_PORT = 2'd3;

    // Word part of word_select
    localparam logic [1:0] WRD_VALUE = 2'd0;
    localparam logic [1:0] WRD_MASK  = 2'd1;
    localparam logic [1:0] WRD_MODE  = 2'd2;
    localparam logic [1:0] WRD_FIXED = 2'd3;

    // Mode byte after reset: copy, autoinc, fixed, copy
    localparam logic [7:0] MODE_RESET = {MODE_COPY, MODE_FIXED, MODE_AUTO, MODE_COPY};

    // One rule row as held in the table memory
    typedef struct packed {
        logic [31:0] sip_val;
        logic [31:0] sip_msk;
        logic [31:0] sip_fix;
        logic [15:0] sp_val;
        logic [15:0] sp_msk;
        logic [15:0] sp_fix;
        logic [31:0] dip_val;
        logic [31:0] dip_msk;
        logic [31:0] dip_fix;
        logic [15:0] dp_val;
        logic [15:0] dp_msk;
        logic [15:0] dp_fix;
        logic [7:0]  modes;
    } rule_row_t;

    localparam rule_row_t RULE_RESET = '{
        sip_val: 32'd0, sip_msk: 32'd0, sip_fix: 32'd0,
        sp_val:  16'd0, sp_msk:  16'd0, sp_fix:  16'd0,
        dip_val: 32'd0, dip_msk: 32'd0, dip_fix: 32'd0,
        dp_val:  16'd0, dp_msk:  16'd0, dp_fix:  16'd0,
        modes:   MODE_RESET
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_SCAN  = 4'b0100,
        S_HIT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/flow_rule_match_rewrite.sv]
// Flow rule table with first-match masked lookup and key rewrite.
// Rule write: row read at accept, then merged and written back in the write state.
// Lookup: one table row read per cycle; done follows the hit state for a hit at
//   rule k, or the compare of the last of the L rules in use for a miss.
// One word in flight: busy drops with the one-cycle done strobe, which cannot be held off.
// Reset clears the table through per-row valid bits (no sweep), loads the counters.
`default_nettype none

module flow_rule_match_rewrite #(
    parameter int NUM_RULES = frmr_pkg::DEFAULT_NUM_RULES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_data,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [3:0]  rule_slot,
    input  wire logic [3:0]  word_select,
    input  wire logic [31:0] word_value,
    input  wire logic [31:0] key_src_ip,
    input  wire logic [15:0] key_src_port,
    input  wire logic [31:0] key_dst_ip,
    input  wire logic [15:0] key_dst_port,
    // result
    output logic             done,
    output logic             matched,
    output logic [3:0]       hit_rule,
    output logic             rewritten,
    output logic [31:0]      new_src_ip,
    output logic [15:0]      new_src_port,
    output logic [31:0]      new_dst_ip,
    output logic [15:0]      new_dst_port
);

    import frmr_pkg::*;

    localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNT_W = $clog2(NUM_RULES + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [4:0]           rules_in_use_reg;
    logic [NUM_RULES-1:0] row_valid_reg;
    logic                 rd_valid_reg;

    // Auto-increment counters
    logic [31:0] cnt_sip_reg, cnt_sip_next;
    logic [15:0] cnt_sp_reg,  cnt_sp_next;
    logic [31:0] cnt_dip_reg, cnt_dip_next;
    logic [15:0] cnt_dp_reg,  cnt_dp_next;

    // Captured request word
    logic [31:0]      key_sip_reg;
    logic [15:0]      key_sp_reg;
    logic [31:0]      key_dip_reg;
    logic [15:0]      key_dp_reg;
    logic [3:0]       sel_reg;
    logic [31:0]      wval_reg;
    logic             wr_ok_reg;
    logic [IDX_W-1:0] wr_addr_reg;

    // Table memory
    rule_row_t        rule_mem [NUM_RULES];
    rule_row_t        rd_data_reg;
    rule_row_t        row_eff;
    rule_row_t        row_mod;
    logic             mem_re;
    logic             mem_we;
    logic [IDX_W-1:0] rd_addr;

    // Result registers
    logic        done_reg,      done_next;
    logic        matched_reg,   matched_next;
    logic [3:0]  hit_reg,       hit_next;
    logic        rewritten_reg, rewritten_next;
    logic [31:0] nsip_reg,      nsip_next;
    logic [15:0] nsp_reg,       nsp_next;
    logic [31:0] ndip_reg,      ndip_next;
    logic [15:0] ndp_reg,       ndp_next;

    logic             accept;
    logic             slot_ok;
    logic [CNT_W-1:0] limit;
    logic             row_match;
    logic             scan_rd;
    logic [1:0]       m_sip, m_sp, m_dip, m_dp;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign slot_ok = (32'(rule_slot) < NUM_RULES);

    // Clamp the rule count to the table depth
    assign limit = (CMP_W'(rules_in_use_reg) >= CMP_W'(NUM_RULES)) ?
                   CNT_W'(NUM_RULES) : CNT_W'(rules_in_use_reg);

    // Rows never written read as the reset rule
    assign row_eff = rd_valid_reg ? rd_data_reg : RULE_RESET;

    // Masked compare of the row under test
    assign row_match = ((key_sip_reg & row_eff.sip_msk) == row_eff.sip_val) &&
                       ((key_sp_reg  & row_eff.sp_msk)  == row_eff.sp_val)  &&
                       ((key_dip_reg & row_eff.dip_msk) == row_eff.dip_val) &&
                       ((key_dp_reg  & row_eff.dp_msk)  == row_eff.dp_val);

    assign m_sip = row_eff.modes[1:0];
    assign m_sp  = row_eff.modes[3:2];
    assign m_dip = row_eff.modes[5:4];
    assign m_dp  = row_eff.modes[7:6];

    // Issue the next scan read unless the pending row hit or no rule is left
    assign scan_rd = (state_reg == S_SCAN) && !(cmp_vld_reg && row_match) &&
                     (scan_cnt_reg < limit);

    assign mem_re  = (accept && (op == OP_WRITE) && slot_ok) || scan_rd;
    assign mem_we  = (state_reg == S_WRITE) && wr_ok_reg;
    assign rd_addr = (state_reg == S_IDLE) ? IDX_W'(rule_slot) : scan_cnt_reg[IDX_W-1:0];

    // Merge one written word into the row
    always_comb
    begin
        row_mod = row_eff;
        if (sel_reg[1:0] == WRD_MODE) begin
            unique case (sel_reg[3:2])
                FLD_SRC_IP:   row_mod.modes[1:0] = wval_reg[1:0];
                FLD_SRC_PORT: row_mod.modes[3:2] = wval_reg[1:0];
                FLD_DST_IP:   row_mod.modes[5:4] = wval_reg[1:0];
                FLD_DST_PORT: row_mod.modes[7:6] = wval_reg[1:0];
                default:      row_mod.modes      = row_eff.modes;
            endcase
        end else begin
            unique case ({sel_reg[3:2], sel_reg[1:0]})
                {FLD_SRC_IP,   WRD_VALUE}: row_mod.sip_val = wval_reg;
                {FLD_SRC_IP,   WRD_MASK}:  row_mod.sip_msk = wval_reg;
                {FLD_SRC_IP,   WRD_FIXED}: row_mod.sip_fix = wval_reg;
                {FLD_SRC_PORT, WRD_VALUE}: row_mod.sp_val  = wval_reg[15:0];
                {FLD_SRC_PORT, WRD_MASK}:  row_mod.sp_msk  = wval_reg[15:0];
                {FLD_SRC_PORT, WRD_FIXED}: row_mod.sp_fix  = wval_reg[15:0];
                {FLD_DST_IP,   WRD_VALUE}: row_mod.dip_val = wval_reg;
                {FLD_DST_IP,   WRD_MASK}:  row_mod.dip_msk = wval_reg;
                {FLD_DST_IP,   WRD_FIXED}: row_mod.dip_fix = wval_reg;
                {FLD_DST_PORT, WRD_VALUE}: row_mod.dp_val  = wval_reg[15:0];
                {FLD_DST_PORT, WRD_MASK}:  row_mod.dp_msk  = wval_reg[15:0];
                {FLD_DST_PORT, WRD_FIXED}: row_mod.dp_fix  = wval_reg[15:0];
                default:                   row_mod         = row_eff;
            endcase
        end
    end

    // Sequencer, counters and result
    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        cnt_sip_next   = cnt_sip_reg;
        cnt_sp_next    = cnt_sp_reg;
        cnt_dip_next   = cnt_dip_reg;
        cnt_dp_next    = cnt_dp_reg;
        done_next      = 1'b0;
        matched_next   = matched_reg;
        hit_next       = hit_reg;
        rewritten_next = rewritten_reg;
        nsip_next      = nsip_reg;
        nsp_next       = nsp_reg;
        ndip_next      = ndip_reg;
        ndp_next       = ndp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    scan_cnt_next = '0;
                    cmp_vld_next  = 1'b0;
                    state_next    = (op == OP_WRITE) ? S_WRITE : S_SCAN;
                end
            end
            S_WRITE:
            begin
                // echo the key for a write
                done_next      = 1'b1;
                matched_next   = 1'b0;
                hit_next       = 4'd0;
                rewritten_next = 1'b0;
                nsip_next      = key_sip_reg;
                nsp_next       = key_sp_reg;
                ndip_next      = key_dip_reg;
                ndp_next       = key_dp_reg;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && row_match) begin
                    state_next = S_HIT;
                end else if (scan_cnt_reg < limit) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else begin
                    // no rule matched: pass the key through
                    done_next      = 1'b1;
                    matched_next   = 1'b0;
                    hit_next       = 4'd0;
                    rewritten_next = 1'b0;
                    nsip_next      = key_sip_reg;
                    nsp_next       = key_sp_reg;
                    ndip_next      = key_dip_reg;
                    ndp_next       = key_dp_reg;
                    state_next     = S_IDLE;
                end
            end
            S_HIT:
            begin
                nsip_next = key_sip_reg;
                nsp_next  = key_sp_reg;
                ndip_next = key_dip_reg;
                ndp_next  = key_dp_reg;
                if (m_sip == MODE_AUTO) begin
                    nsip_next    = cnt_sip_reg;
                    cnt_sip_next = cnt_sip_reg + 32'd1;
                end else if (m_sip == MODE_FIXED) begin
                    nsip_next = row_eff.sip_fix;
                end
                if (m_sp == MODE_AUTO) begin
                    nsp_next    = cnt_sp_reg;
                    cnt_sp_next = cnt_sp_reg + 16'd1;
                end else if (m_sp == MODE_FIXED) begin
                    nsp_next = row_eff.sp_fix;
                end
                if (m_dip == MODE_AUTO) begin
                    ndip_next    = cnt_dip_reg;
                    cnt_dip_next = cnt_dip_reg + 32'd1;
                end else if (m_dip == MODE_FIXED) begin
                    ndip_next = row_eff.dip_fix;
                end
                if (m_dp == MODE_AUTO) begin
                    ndp_next    = cnt_dp_reg;
                    cnt_dp_next = cnt_dp_reg + 16'd1;
                end else if (m_dp == MODE_FIXED) begin
                    ndp_next = row_eff.dp_fix;
                end
                done_next      = 1'b1;
                matched_next   = 1'b1;
                hit_next       = 4'(cmp_idx_reg);
                rewritten_next = (nsip_next != key_sip_reg) || (nsp_next != key_sp_reg) ||
                                 (ndip_next != key_dip_reg) || (ndp_next != key_dp_reg);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            scan_cnt_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            rules_in_use_reg <= 5'd0;
            row_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            cnt_sip_reg      <= 32'd0;
            cnt_sp_reg       <= PORT_CNT_START;
            cnt_dip_reg      <= 32'd0;
            cnt_dp_reg       <= PORT_CNT_START;
            done_reg         <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            cnt_sip_reg  <= cnt_sip_next;
            cnt_sp_reg   <= cnt_sp_next;
            cnt_dip_reg  <= cnt_dip_next;
            cnt_dp_reg   <= cnt_dp_next;
            done_reg     <= done_next;
            if (cfg_we) begin
                rules_in_use_reg <= cfg_data;
            end
            if (mem_re) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (mem_we) begin
                row_valid_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        matched_reg    <= matched_next;
        hit_reg        <= hit_next;
        rewritten_reg  <= rewritten_next;
        nsip_reg       <= nsip_next;
        nsp_reg        <= nsp_next;
        ndip_reg       <= ndip_next;
        ndp_reg        <= ndp_next;
        if (accept) begin
            key_sip_reg <= key_src_ip;
            key_sp_reg  <= key_src_port;
            key_dip_reg <= key_dst_ip;
            key_dp_reg  <= key_dst_port;
            sel_reg     <= word_select;
            wval_reg    <= word_value;
            wr_ok_reg   <= slot_ok;
            wr_addr_reg <= IDX_W'(rule_slot);
        end
    end

    // Rule table: one read port, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            rule_mem[wr_addr_reg] <= row_mod;
        end
        if (mem_re) begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    assign done         = done_reg;
    assign matched      = matched_reg;
    assign hit_rule     = hit_reg;
    assign rewritten    = rewritten_reg;
    assign new_src_ip   = nsip_reg;
    assign new_src_port = nsp_reg;
    assign new_dst_ip   = ndip_reg;
    assign new_dst_port = ndp_reg;

    // A result follows only from a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    // The table is written back only by the write step
    a_write_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WRITE))
        else $error("table write outside the write step");

    // A rewrite is only reported for a hit
    a_rewrite_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rewritten) |-> matched)
        else $error("rewritten without a match");

    // Counters move only on a hit
    a_cnt_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(cnt_sip_reg) || !$stable(cnt_sp_reg) ||
         !$stable(cnt_dip_reg) || !$stable(cnt_dp_reg)) |-> $past(state_reg == S_HIT))
        else $error("counter advanced without a hit");

    // Scan reads stay within the rules in use
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_rd |-> (scan_cnt_reg < limit))
        else $error("scan read beyond the rules in use");

endmodule

`default_nettype wire
